### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// Types and constants shared by the keyed record table modules.
// ----------------------------------------------------------------------------
package krt_pkg;

    // Default table depth.
    localparam int CAPACITY_DEF = 16;

    // Record layout: key, year, three courses, three grades, eight bits each.
    localparam int KEY_W = 8;
    localparam int REC_W = 64;
    localparam logic [7:0] GRADE_MAX = 8'd100;

    // Output word layout, lowest bit first.
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_REC_LSB    = 2;
    localparam int OUT_COUNT_LSB  = OUT_REC_LSB + REC_W;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DEL    = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_LIST   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_GRADE = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } t_state;

    // Controls broadcast to every cell of the chain.
    typedef struct packed {
        logic load_match;
        logic ins;
        logic del;
        logic rot;
    } t_cell_ctl;

endpackage

### rtl/krt_cell.sv
// ----------------------------------------------------------------------------
// krt_cell
// One table position: holds a record and its valid bit, and moves data to
// or from its neighbors on insert, delete and list rotation.
// ----------------------------------------------------------------------------
module krt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  krt_pkg::t_cell_ctl        i_ctl,
    input  logic                      i_del_sel,
    input  logic [krt_pkg::KEY_W-1:0] i_key,
    input  logic [krt_pkg::REC_W-1:0] i_prev_rec,
    input  logic                      i_prev_valid,
    input  logic [krt_pkg::REC_W-1:0] i_next_rec,
    input  logic                      i_next_valid,
    input  logic [krt_pkg::REC_W-1:0] i_head_rec,
    output logic [krt_pkg::REC_W-1:0] o_rec,
    output logic                      o_valid,
    output logic                      o_match
);
    import krt_pkg::*;

    logic [REC_W-1:0] r_rec;
    logic             r_valid;
    logic             r_match;

    // Valid bit follows the record it belongs to.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins) begin
            r_valid <= i_prev_valid;
        end else if (i_ctl.del && i_del_sel) begin
            r_valid <= i_next_valid;
        end
    end

    // Record payload: shift toward the back on insert, toward the front on
    // delete, and rotate among the valid cells while the keys are listed.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            r_rec <= i_prev_rec;
        end else if (i_ctl.del && i_del_sel) begin
            r_rec <= i_next_rec;
        end else if (i_ctl.rot && r_valid) begin
            r_rec <= i_next_valid ? i_next_rec : i_head_rec;
        end
    end

    // Key compare is captured when a command is accepted.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_match) begin
            r_match <= r_valid && (r_rec[KEY_W-1:0] == i_key);
        end
    end

    assign o_rec   = r_rec;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

### rtl/krt_chain.sv
// ----------------------------------------------------------------------------
// krt_chain
// Row of table cells with the first-match selection that drives delete and
// lookup.
// ----------------------------------------------------------------------------
module krt_chain #(
    parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  krt_pkg::t_cell_ctl        i_ctl,
    input  logic [krt_pkg::KEY_W-1:0] i_key,
    input  logic [krt_pkg::REC_W-1:0] i_new_rec,
    output logic                      o_hit_any,
    output logic [krt_pkg::REC_W-1:0] o_hit_rec,
    output logic [krt_pkg::KEY_W-1:0] o_head_key,
    output logic [CAPACITY-1:0]       o_valid
);
    import krt_pkg::*;

    logic [REC_W-1:0]    cell_rec [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_match;
    logic [CAPACITY-1:0] first_hit;
    logic [CAPACITY-1:0] del_mask;

    // The newest match is the lowest set bit; every cell from it onward
    // moves forward on delete.
    assign first_hit = cell_match & ~(cell_match - CAPACITY'(1));
    assign o_hit_any = |cell_match;
    assign del_mask  = o_hit_any ? ~(first_hit - CAPACITY'(1)) : '0;

    // Record of the newest match, selected by its one-hot flag.
    always_comb begin
        o_hit_rec = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            o_hit_rec = o_hit_rec | (cell_rec[i] & {REC_W{first_hit[i]}});
        end
    end

    // Cell row; cell 0 is the newest record.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [REC_W-1:0] prev_rec;
        logic             prev_valid;
        logic [REC_W-1:0] next_rec;
        logic             next_valid;

        if (i == 0) begin : g_first
            assign prev_rec   = i_new_rec;
            assign prev_valid = 1'b1;
        end else begin : g_mid
            assign prev_rec   = cell_rec[i-1];
            assign prev_valid = cell_valid[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign next_rec   = '0;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_rec   = cell_rec[i+1];
            assign next_valid = cell_valid[i+1];
        end

        krt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_del_sel    (del_mask[i]),
            .i_key        (i_key),
            .i_prev_rec   (prev_rec),
            .i_prev_valid (prev_valid),
            .i_next_rec   (next_rec),
            .i_next_valid (next_valid),
            .i_head_rec   (cell_rec[0]),
            .o_rec        (cell_rec[i]),
            .o_valid      (cell_valid[i]),
            .o_match      (cell_match[i])
        );
    end

    assign o_head_key = cell_rec[0][KEY_W-1:0];
    assign o_valid    = cell_valid;

endmodule

### rtl/keyed_record_table.sv
// Add, delete and lookup capture the key compare in every cell when the command is accepted;
// the execute state then acts on the first match and registers the result once the output
// register can take it. A list leaves the execute state for the list state, which registers
// one key per cycle while the result channel accepts, as the cell row rotates.
// Reset clears the valid bits and the record count; records themselves are not cleared.
// ----------------------------------------------------------------------------
// keyed_record_table
// Bounded newest-first record table with add, delete, lookup and key list
// commands, built as a chain of record cells under a small sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_record_table #(
    parameter int CAPACITY = krt_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((krt_pkg::OUT_COUNT_LSB + CNT_W + 1 + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Command channel.
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // tdata: student_key, entry_year, course_a, course_b, course_c,
    //        grade_a, grade_b, grade_c
    input  logic [krt_pkg::REC_W-1:0] i_s_axis_tdata,
    // tuser: cmd
    input  logic [1:0]                i_s_axis_tuser,
    // Result channel.
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // tdata: status, out_key, out_year, out_course_a, out_course_b,
    //        out_course_c, out_grade_a, out_grade_b, out_grade_c,
    //        used_count, table_full, zero padding
    output logic [OUT_W-1:0]          o_m_axis_tdata,
    // tlast: last_of_run
    output logic                      o_m_axis_tlast
);
    import krt_pkg::*;

    t_state           r_state, n_state;
    t_cmd             r_cmd;
    logic [REC_W-1:0] r_rec;
    logic             r_bad_grade;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_last;

    t_cell_ctl        ctl;
    logic             in_xfer;
    logic             can_emit;
    logic             emit;
    t_status          e_status;
    logic [REC_W-1:0] e_rec;
    logic             e_last;
    logic [OUT_W-1:0] e_word;

    logic                hit_any;
    logic [REC_W-1:0]    hit_rec;
    logic [KEY_W-1:0]    head_key;
    logic [CAPACITY-1:0] valid_vec;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign can_emit        = !r_out_valid || i_m_axis_tready;

    // Cell row.
    krt_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_key      (i_s_axis_tdata[KEY_W-1:0]),
        .i_new_rec  (r_rec),
        .o_hit_any  (hit_any),
        .o_hit_rec  (hit_rec),
        .o_head_key (head_key),
        .o_valid    (valid_vec)
    );

    // Command capture.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd       <= t_cmd'(i_s_axis_tuser);
            r_rec       <= i_s_axis_tdata;
            r_bad_grade <= (i_s_axis_tdata[47:40] > GRADE_MAX) ||
                           (i_s_axis_tdata[55:48] > GRADE_MAX) ||
                           (i_s_axis_tdata[63:56] > GRADE_MAX);
        end
    end

    // Sequencer state, count and remaining list length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
        end
    end

    // Next state, cell controls and result contents.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        ctl      = '0;
        emit     = 1'b0;
        e_status = ST_OK;
        e_rec    = '0;
        e_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    ctl.load_match = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_emit) begin
                    n_state = S_IDLE;
                    case (r_cmd)
                        CMD_ADD: begin
                            emit = 1'b1;
                            if (r_count == CNT_W'(CAPACITY)) begin
                                e_status = ST_FULL;
                            end else if (r_bad_grade) begin
                                e_status = ST_GRADE;
                            end else begin
                                ctl.ins = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_DEL: begin
                            emit = 1'b1;
                            if (!hit_any) begin
                                e_status = ST_MISS;
                            end else begin
                                ctl.del = 1'b1;
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        CMD_LOOKUP: begin
                            emit = 1'b1;
                            if (!hit_any) begin
                                e_status = ST_MISS;
                            end else begin
                                e_rec = hit_rec;
                            end
                        end
                        CMD_LIST: begin
                            if (r_count == '0) begin
                                emit     = 1'b1;
                                e_status = ST_MISS;
                            end else begin
                                n_left  = r_count;
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    ctl.rot = 1'b1;
                    e_rec   = {{(REC_W - KEY_W){1'b0}}, head_key};
                    e_last  = (r_left == CNT_W'(1));
                    n_left  = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result word assembly.
    always_comb begin
        e_word                                  = '0;
        e_word[OUT_STATUS_LSB +: 2]             = e_status;
        e_word[OUT_REC_LSB +: REC_W]            = e_rec;
        e_word[OUT_COUNT_LSB +: CNT_W]          = n_count;
        e_word[OUT_COUNT_LSB + CNT_W]           = (n_count == CNT_W'(CAPACITY));
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= e_word;
            r_out_last <= e_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // Checks on count, cell valid bits and list sequencing.
    `ASSERT_SAME(a_count_range, 1'b1, r_count <= CNT_W'(CAPACITY))
    `ASSERT_SAME(a_valid_count, 1'b1, $countones(valid_vec) == r_count)
    `ASSERT_SAME(a_list_left, r_state == S_LIST, r_left != '0)
    `ASSERT_NEXT(a_add_count, ctl.ins, r_count == $past(r_count) + CNT_W'(1))
    `ASSERT_NEXT(a_del_count, ctl.del, r_count == $past(r_count) - CNT_W'(1))

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// Keyed record table testbench
// Drives add, delete, lookup and key-list commands into the stream port and
// checks every result transfer against a predictor of the newest-first table.
// Directed corner cases come first. Capacity, random traffic, a long result
// hold-off and back-to-back streaming follow.
// ----------------------------------------------------------------------------
module tb;
    import krt_pkg::*;

    localparam int CAP            = CAPACITY_DEF;
    localparam int CNT_W          = $clog2(CAP + 1);
    localparam int OUT_W          = ((OUT_COUNT_LSB + CNT_W + 1 + 7) / 8) * 8;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = CAP + 8;

    // One record, key in the lowest byte, as it travels in the command tdata.
    typedef struct packed {
        logic [7:0] grade_c, grade_b, grade_a, course_c, course_b, course_a, year, key;
    } t_record;

    // One result transfer: tlast on top of the packed tdata fields.
    typedef struct packed {
        logic             last;
        logic             full;
        logic [CNT_W-1:0] count;
        t_record          rec;
        t_status          status;
    } t_table_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic [REC_W-1:0] s_data = '0;
    logic [1:0]       s_user = CMD_ADD;
    logic             m_ready = 1'b0;
    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             o_m_axis_tlast;

    // Predicted table contents, newest record at index 0.
    t_record       rows[$];
    t_table_result expected_results[$];
    int            error_count = 0;
    int            quiet_cycles = 0;
    bit            idling_on = 1'b1;
    bit            hold_request = 1'b0;

    keyed_record_table i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Update the predicted table for one accepted command and queue its results.
    task automatic predict_table(input t_cmd cmd, input t_record item);
        t_table_result res;
        int pos;
        res = '0;
        res.last = 1'b1;
        pos = -1;
        foreach (rows[i]) if (pos < 0 && rows[i].key == item.key) pos = i;
        case (cmd)
            CMD_ADD: begin
                // Fullness is checked before the grades.
                if (rows.size() >= CAP) begin
                    res.status = ST_FULL;
                end else if (item.grade_a > GRADE_MAX || item.grade_b > GRADE_MAX ||
                             item.grade_c > GRADE_MAX) begin
                    res.status = ST_GRADE;
                end else begin
                    rows.push_front(item);
                    res.status = ST_OK;
                end
            end
            CMD_DEL: begin
                if (pos < 0) begin
                    res.status = ST_MISS;
                end else begin
                    rows.delete(pos);
                    res.status = ST_OK;
                end
            end
            CMD_LOOKUP: begin
                if (pos < 0) begin
                    res.status = ST_MISS;
                end else begin
                    res.rec = rows[pos];
                    res.status = ST_OK;
                end
            end
            default: begin
                // A list of a non-empty table gives one key per record.
                if (rows.size() == 0) begin
                    res.status = ST_MISS;
                end else begin
                    res.status = ST_OK;
                    res.count = CNT_W'(rows.size());
                    res.full = (rows.size() == CAP);
                    foreach (rows[i]) begin
                        res.rec.key = rows[i].key;
                        res.last = (i == rows.size() - 1);
                        expected_results.push_back(res);
                    end
                    return;
                end
            end
        endcase
        res.count = CNT_W'(rows.size());
        res.full = (rows.size() == CAP);
        expected_results.push_back(res);
    endtask

    // Send one command transfer; returns at the falling edge after acceptance.
    task automatic send_cmd(input t_cmd cmd, input t_record item);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= cmd;
        s_data <= item;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_table(cmd, item);
        @(negedge i_clk);
    endtask

    // Stop offering commands and wait until every expected result has come.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0);
    endtask

    function automatic t_record make_rec(input logic [7:0] key, year, ca, cb, cc, ga, gb, gc);
        make_rec = '{grade_c: gc, grade_b: gb, grade_a: ga, course_c: cc, course_b: cb,
                     course_a: ca, year: year, key: key};
    endfunction

    // Random record; keys mostly from a small pool so that matches are common.
    function automatic t_record random_record(input bit bad_grades);
        t_record r;
        r[31:0] = $urandom;
        r[63:32] = $urandom;
        r.key = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 11));
        r.grade_a = (bad_grades && $urandom_range(0, 9) == 0) ? 8'($urandom_range(101, 255))
                                                              : 8'($urandom_range(0, 100));
        r.grade_b = (bad_grades && $urandom_range(0, 9) == 0) ? 8'($urandom_range(101, 255))
                                                              : 8'($urandom_range(0, 100));
        r.grade_c = (bad_grades && $urandom_range(0, 9) == 0) ? 8'($urandom_range(101, 255))
                                                              : 8'($urandom_range(0, 100));
        return r;
    endfunction

    // Mixed random commands; add_pct steers the table toward empty or full.
    task automatic send_random(input int count, input int add_pct);
        int roll;
        t_cmd cmd;
        t_record item;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            item = random_record(1'b1);
            if (roll < add_pct) cmd = CMD_ADD;
            else if (roll < add_pct + 22) cmd = CMD_DEL;
            else if (roll < add_pct + 44) cmd = CMD_LOOKUP;
            else cmd = CMD_LIST;
            // Delete and lookup mostly aim at a key that is present.
            if (cmd inside {CMD_DEL, CMD_LOOKUP} && rows.size() > 0 &&
                $urandom_range(0, 9) < 7)
                item.key = rows[$urandom_range(0, rows.size() - 1)].key;
            send_cmd(cmd, item);
        end
    endtask

    task automatic test_directed();
        send_cmd(CMD_LIST, '0);
        send_cmd(CMD_LOOKUP, '0);
        send_cmd(CMD_DEL, make_rec(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(CMD_ADD, make_rec(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(CMD_ADD, make_rec(8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                   8'd100, 8'd100, 8'd100));
        // Grades just above the limit and at the top of the range.
        send_cmd(CMD_ADD, make_rec(8'd9, 8'd1, 8'd2, 8'd3, 8'd4, 8'd101, 8'd0, 8'd0));
        send_cmd(CMD_ADD, make_rec(8'd9, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd255, 8'd0));
        send_cmd(CMD_ADD, make_rec(8'd9, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd0, 8'd101));
        // A duplicate key: lookup and delete act on the newest one.
        send_cmd(CMD_ADD, make_rec(8'd0, 8'd1, 8'd170, 8'd85, 8'd15, 8'd50, 8'd1, 8'd99));
        send_cmd(CMD_LOOKUP, make_rec(8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
                                      8'd255, 8'd255, 8'd255));
        send_cmd(CMD_LOOKUP, make_rec(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(CMD_LIST, '1);
        send_cmd(CMD_DEL, make_rec(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        // The remaining key 0 record now sits in the oldest position.
        send_cmd(CMD_LOOKUP, make_rec(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(CMD_DEL, make_rec(8'd77, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(CMD_LIST, '0);
        send_cmd(CMD_DEL, make_rec(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(CMD_DEL, make_rec(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(CMD_LIST, '0);
        wait_for_results();
    endtask

    task automatic test_capacity();
        t_record bad;
        while (rows.size() < CAP) send_cmd(CMD_ADD, random_record(1'b0));
        send_cmd(CMD_ADD, random_record(1'b0));
        // Full wins over a bad grade.
        bad = random_record(1'b0);
        bad.grade_b = 8'd200;
        send_cmd(CMD_ADD, bad);
        send_cmd(CMD_LIST, random_record(1'b0));
        send_cmd(CMD_LOOKUP, rows[CAP - 1]);
        send_cmd(CMD_DEL, rows[CAP - 1]);
        send_cmd(CMD_ADD, random_record(1'b0));
        send_cmd(CMD_LIST, '0);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        // Segments turn idling on or off at random and steer the fill level up and down.
        repeat (4) begin
            idling_on = ($urandom_range(0, 2) != 0);
            send_random(50, $urandom_range(15, 55));
        end
        idling_on = 1'b1;
        wait_for_results();
    endtask

    task automatic test_backpressure();
        while (rows.size() < 10) send_cmd(CMD_ADD, random_record(1'b0));
        idling_on = 1'b0;
        hold_request = 1'b1;
        repeat (10) begin
            send_cmd(CMD_LIST, random_record(1'b1));
            send_cmd(CMD_LOOKUP, rows[$urandom_range(0, rows.size() - 1)]);
        end
        idling_on = 1'b1;
        wait_for_results();
    endtask

    task automatic test_streaming_tail();
        idling_on = 1'b0;
        send_random(60, 35);
        wait_for_results();
    endtask

    // Result receiver: random stall bursts and one long hold-off on request.
    initial begin : result_sink
        int stall;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                m_ready <= 1'b0;
                hold_request = 1'b0;
                for (stall = 1; stall < HOLD_CYCLES; stall++) @(negedge i_clk);
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic compare_field(input string name, input logic [7:0] want, got_v);
        if (got_v !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got_v);
            error_count++;
        end
    endtask

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_table_result want;
        t_table_result got;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got = {o_m_axis_tlast, o_m_axis_tdata[OUT_COUNT_LSB + CNT_W:0]};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("status", 8'(want.status), 8'(got.status));
                compare_field("out_key", want.rec.key, got.rec.key);
                compare_field("out_year", want.rec.year, got.rec.year);
                compare_field("out_course_a", want.rec.course_a, got.rec.course_a);
                compare_field("out_course_b", want.rec.course_b, got.rec.course_b);
                compare_field("out_course_c", want.rec.course_c, got.rec.course_c);
                compare_field("out_grade_a", want.rec.grade_a, got.rec.grade_a);
                compare_field("out_grade_b", want.rec.grade_b, got.rec.grade_b);
                compare_field("out_grade_c", want.rec.grade_c, got.rec.grade_c);
                compare_field("used_count", 8'(want.count), 8'(got.count));
                compare_field("table_full", 8'(want.full), 8'(got.full));
                compare_field("last_of_run", 8'(want.last), 8'(got.last));
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_capacity();
        test_random_traffic();
        test_backpressure();
        test_streaming_tail();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### keyed_record_table.f
+incdir+rtl
rtl/krt_pkg.sv
rtl/krt_cell.sv
rtl/krt_chain.sv
rtl/keyed_record_table.sv
test/tb.sv
